### hw/rtl/lcd4_pkg.sv
// Package for the character LCD 4-bit write sequencer.
// Holds kind codes, fixed bytes and the command/status types between controller and datapath.
// No dependencies; the sequencer modules and the testbench import it.
`default_nettype none

package lcd4_pkg;

    // Default number of decimal digits kept for the number kind.
    localparam int MAX_DIGITS_DFLT = 10;

    // Request kinds.
    localparam logic [2:0] KIND_INIT   = 3'd0;
    localparam logic [2:0] KIND_CMD    = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_CURSOR = 3'd3;
    localparam logic [2:0] KIND_NUMBER = 3'd4;

    // Configuration register indexes.
    localparam int         CFG_IDX_W = 1;
    localparam logic       CFG_PULSE = 1'b0;
    localparam logic       CFG_POWER = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0] PULSE_MS_RST = 8'd1;
    localparam logic [7:0] POWER_MS_RST = 8'd40;

    // Fixed nibbles and bytes of the controller protocol.
    localparam logic [3:0] NIB_INIT_A      = 4'h2;
    localparam logic [3:0] NIB_INIT_B      = 4'h8;
    localparam logic [7:0] BYTE_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] BYTE_CLEAR      = 8'h01;
    localparam logic [7:0] ASCII_ZERO      = 8'd48;

    // Reciprocal of ten: floor(v / 10) = (v * RECIP_10) >> RECIP_SHIFT for any 32-bit v.
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Source of the byte loaded into the datapath byte register.
    typedef enum logic [2:0] {
        BSEL_VALUE,
        BSEL_CURSOR,
        BSEL_DISPLAY_ON,
        BSEL_CLEAR,
        BSEL_ZERO_CHAR,
        BSEL_DIGIT
    } t_byte_sel;

    // Source of the data lines for an emitted segment.
    typedef enum logic [2:0] {
        NSEL_KEEP,
        NSEL_HIGH,
        NSEL_LOW,
        NSEL_INIT_A,
        NSEL_INIT_B
    } t_nib_sel;

    // Source of the hold time for an emitted segment.
    typedef enum logic [1:0] {
        HSEL_ZERO,
        HSEL_PULSE,
        HSEL_POWER
    } t_hold_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_item;
        logic      load_byte;
        t_byte_sel byte_sel;
        logic      pop;
        logic      mul;
        logic      sub;
        logic      emit;
        logic      rs_we;
        logic      rs_val;
        logic      en;
        t_nib_sel  nib_sel;
        t_hold_sel hold_sel;
        logic      last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic value_zero;
        logic quot_zero;
        logic ndig_last;
        logic ndig_zero;
    } t_dp_stat;

endpackage

`default_nettype wire

### hw/rtl/lcd4_cmd_if.sv
// Request channel of the LCD sequencer: valid/ready handshake and one request word.
// No dependencies.
`default_nettype none

interface lcd4_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [5:0]  column;
    logic        row;

    modport source (output valid, kind, value, column, row, input ready);
    modport sink   (input valid, kind, value, column, row, output ready);
endinterface

`default_nettype wire

### hw/rtl/lcd4_seg_if.sv
// Segment channel of the LCD sequencer: valid/ready handshake and one pin-segment word.
// No dependencies.
`default_nettype none

interface lcd4_seg_if;
    logic       valid;
    logic       ready;
    logic       register_select;
    logic       enable;
    logic [3:0] nibble;
    logic [7:0] hold_ms;
    logic       last;

    modport source (output valid, register_select, enable, nibble, hold_ms, last, input ready);
    modport sink   (input valid, register_select, enable, nibble, hold_ms, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/char_lcd_nibble_write_sequencer.sv
// Character LCD 4-bit write sequencer, top level.
// Requests come in on i_cmd: kind 0 init, 1 command byte, 2 data byte,
// 3 cursor position, 4 decimal number; kinds 5 to 7 are taken and dropped.
// Each request produces a train of pin-segment words on o_seg (RS, E, D4..D7,
// hold time in ms); the final word of a request carries last.
// A byte is four words: high nibble with E high, E low, low nibble with E high,
// E low. Init gives 15 words, a command, data or cursor request 4 words, and
// a number 4 words per digit (at most MAX_DIGITS digits, lowest ones kept).
// One request is worked at a time; i_cmd.ready is high only when idle.
// Words leave at one per cycle while o_seg.ready is high, with a load step
// between the bytes of a number. For a number, each digit first takes a multiply
// and a subtract step in the shared divide-by-ten unit; then each digit has its
// character loaded and goes out as four output words.
// A stalled receiver holds the current word in the output register and the
// sequencer waits; nothing is dropped.
// Reset (synchronous, active low) returns to idle, clears RS and the data
// lines and loads pulse time 1 ms and power-up wait 40 ms. The config port
// i_cfg_we/i_cfg_idx/i_cfg_data writes register 0 (pulse) or 1 (power-up).
// Depends on lcd4_pkg, lcd4_cmd_if, lcd4_seg_if, lcd4_ctrl and lcd4_dpath.
`default_nettype none

module char_lcd_nibble_write_sequencer
    import lcd4_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DFLT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    lcd4_cmd_if.sink                  i_cmd,
    lcd4_seg_if.source                o_seg,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;
    logic       w_in_ready;
    logic       w_out_valid;
    logic       w_rs;
    logic       w_en;
    logic [3:0] w_nib;
    logic [7:0] w_hold;
    logic       w_last;

    // Sequencing of each request.
    lcd4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .i_kind     (i_cmd.kind),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Registers, digit conversion and output word.
    lcd4_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_value           (i_cmd.value),
        .i_column          (i_cmd.column),
        .i_row             (i_cmd.row),
        .o_out_valid       (w_out_valid),
        .i_out_ready       (o_seg.ready),
        .o_register_select (w_rs),
        .o_enable          (w_en),
        .o_nibble          (w_nib),
        .o_hold_ms         (w_hold),
        .o_last            (w_last)
    );

    // Channel hookup.
    assign i_cmd.ready           = w_in_ready;
    assign o_seg.valid           = w_out_valid;
    assign o_seg.register_select = w_rs;
    assign o_seg.enable          = w_en;
    assign o_seg.nibble          = w_nib;
    assign o_seg.hold_ms         = w_hold;
    assign o_seg.last            = w_last;

endmodule

`default_nettype wire

### hw/rtl/lcd4_dpath.sv
// Datapath of the LCD sequencer: config registers, byte register, divide-by-ten unit,
// digit store, pin state and the output word register. Depends on lcd4_pkg.
`default_nettype none

module lcd4_dpath
    import lcd4_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DFLT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data,
    input  wire logic [31:0]          i_value,
    input  wire logic [5:0]           i_column,
    input  wire logic                 i_row,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_register_select,
    output logic                      o_enable,
    output logic [3:0]                o_nibble,
    output logic [7:0]                o_hold_ms,
    output logic                      o_last
);

    localparam int NDW  = $clog2(MAX_DIGITS + 1);
    localparam int IDXW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int QW   = 64 - RECIP_SHIFT;

    logic [7:0]     r_pulse_ms;
    logic [7:0]     r_power_ms;
    logic [7:0]     r_byte;
    logic [7:0]     n_byte;
    logic [31:0]    r_value;
    logic [63:0]    r_prod;
    logic [NDW-1:0] r_ndig;
    logic [NDW-1:0] w_ndig_m1;
    logic [3:0]     r_digits [MAX_DIGITS];
    logic [3:0]     w_digit_rd;
    logic [QW-1:0]  w_quot;
    logic [31:0]    w_rem;
    logic           r_rs;
    logic [3:0]     r_data;
    logic           w_seg_rs;
    logic [3:0]     w_seg_nib;
    logic [7:0]     w_seg_hold;
    logic           w_out_free;

    // Quotient and remainder of the registered product.
    assign w_quot     = r_prod[63:RECIP_SHIFT];
    assign w_rem      = r_value - (32'(w_quot) << 3) - (32'(w_quot) << 1);
    assign w_ndig_m1  = r_ndig - NDW'(1);
    assign w_digit_rd = r_digits[w_ndig_m1[IDXW-1:0]];
    assign w_out_free = !o_out_valid || i_out_ready;

    // Status back to the controller.
    assign o_stat.out_free   = w_out_free;
    assign o_stat.value_zero = (r_value == 32'd0);
    assign o_stat.quot_zero  = (w_quot == '0);
    assign o_stat.ndig_last  = (r_ndig == NDW'(MAX_DIGITS - 1));
    assign o_stat.ndig_zero  = (r_ndig == '0);

    // Byte to load into the byte register.
    always_comb begin
        unique case (i_cmd.byte_sel)
            BSEL_VALUE:      n_byte = i_value[7:0];
            BSEL_CURSOR:     n_byte = {1'b1, i_row, i_column};
            BSEL_DISPLAY_ON: n_byte = BYTE_DISPLAY_ON;
            BSEL_CLEAR:      n_byte = BYTE_CLEAR;
            BSEL_ZERO_CHAR:  n_byte = ASCII_ZERO;
            BSEL_DIGIT:      n_byte = {ASCII_ZERO[7:4], w_digit_rd};
            default:         n_byte = ASCII_ZERO;
        endcase
    end

    // Pin levels of the segment being emitted.
    always_comb begin
        w_seg_rs = i_cmd.rs_we ? i_cmd.rs_val : r_rs;
        unique case (i_cmd.nib_sel)
            NSEL_KEEP:   w_seg_nib = r_data;
            NSEL_HIGH:   w_seg_nib = r_byte[7:4];
            NSEL_LOW:    w_seg_nib = r_byte[3:0];
            NSEL_INIT_A: w_seg_nib = NIB_INIT_A;
            NSEL_INIT_B: w_seg_nib = NIB_INIT_B;
            default:     w_seg_nib = r_data;
        endcase
        unique case (i_cmd.hold_sel)
            HSEL_ZERO:  w_seg_hold = 8'd0;
            HSEL_PULSE: w_seg_hold = r_pulse_ms;
            HSEL_POWER: w_seg_hold = r_power_ms;
            default:    w_seg_hold = 8'd0;
        endcase
    end

    // Control state: config registers, digit count, pin state, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ms  <= PULSE_MS_RST;
            r_power_ms  <= POWER_MS_RST;
            r_ndig      <= '0;
            r_rs        <= 1'b0;
            r_data      <= 4'd0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PULSE) begin
                    r_pulse_ms <= i_cfg_data;
                end else if (i_cfg_idx == CFG_POWER) begin
                    r_power_ms <= i_cfg_data;
                end
            end
            if (i_cmd.load_item) begin
                r_ndig <= '0;
            end else if (i_cmd.sub) begin
                r_ndig <= r_ndig + NDW'(1);
            end else if (i_cmd.pop) begin
                r_ndig <= w_ndig_m1;
            end
            if (i_cmd.emit) begin
                r_rs        <= w_seg_rs;
                r_data      <= w_seg_nib;
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: number, product, byte, digit store and output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_value <= i_value;
        end else if (i_cmd.sub) begin
            r_value <= 32'(w_quot);
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(r_value) * 64'(RECIP_10);
        end
        if (i_cmd.sub) begin
            r_digits[r_ndig[IDXW-1:0]] <= w_rem[3:0];
        end
        if (i_cmd.load_byte) begin
            r_byte <= n_byte;
        end
        if (i_cmd.emit) begin
            o_register_select <= w_seg_rs;
            o_enable          <= i_cmd.en;
            o_nibble          <= w_seg_nib;
            o_hold_ms         <= w_seg_hold;
            o_last            <= i_cmd.last;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lcd4_ctrl.sv
// Controller of the LCD sequencer: walks the segment sequence of each request and
// drives the datapath commands. Depends on lcd4_pkg.
`default_nettype none

module lcd4_ctrl
    import lcd4_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_kind,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POWER,
        S_INIT_NIB,
        S_NUM_CHK,
        S_MUL,
        S_SUB,
        S_POP,
        S_BYTE
    } t_state;

    // What follows the byte now being sent.
    typedef enum logic [1:0] {
        MODE_SINGLE,
        MODE_INIT_ON,
        MODE_INIT_CLR,
        MODE_DIGITS
    } t_mode;

    t_state     r_state, n_state;
    t_mode      r_mode, n_mode;
    logic [1:0] r_phase, n_phase;
    logic [1:0] r_idx, n_idx;
    logic       r_rs_byte, n_rs_byte;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_rs_byte = r_rs_byte;
        o_cmd     = '{byte_sel: BSEL_VALUE, nib_sel: NSEL_KEEP, hold_sel: HSEL_ZERO,
                      default: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_phase = 2'd0;
                    n_mode  = MODE_SINGLE;
                    unique case (i_kind)
                        KIND_INIT: begin
                            n_state = S_POWER;
                        end
                        KIND_CMD, KIND_DATA: begin
                            o_cmd.load_byte = 1'b1;
                            o_cmd.byte_sel  = BSEL_VALUE;
                            n_rs_byte       = (i_kind == KIND_DATA);
                            n_state         = S_BYTE;
                        end
                        KIND_CURSOR: begin
                            o_cmd.load_byte = 1'b1;
                            o_cmd.byte_sel  = BSEL_CURSOR;
                            n_rs_byte       = 1'b0;
                            n_state         = S_BYTE;
                        end
                        KIND_NUMBER: begin
                            o_cmd.load_item = 1'b1;
                            n_state         = S_NUM_CHK;
                        end
                        default: begin
                            // Unused kinds are taken and dropped.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_POWER: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.rs_we    = 1'b1;
                    o_cmd.rs_val   = 1'b0;
                    o_cmd.hold_sel = HSEL_POWER;
                    n_phase        = 2'd0;
                    n_idx          = 2'd0;
                    n_state        = S_INIT_NIB;
                end
            end

            // Three single nibbles: 2, 2, then 8.
            S_INIT_NIB: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!r_phase[0]) begin
                        o_cmd.en       = 1'b1;
                        o_cmd.nib_sel  = (r_idx == 2'd2) ? NSEL_INIT_B : NSEL_INIT_A;
                        o_cmd.hold_sel = HSEL_PULSE;
                        n_phase        = 2'd1;
                    end else begin
                        n_phase = 2'd0;
                        if (r_idx == 2'd2) begin
                            o_cmd.load_byte = 1'b1;
                            o_cmd.byte_sel  = BSEL_DISPLAY_ON;
                            n_mode          = MODE_INIT_ON;
                            n_rs_byte       = 1'b0;
                            n_state         = S_BYTE;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end
                end
            end

            S_NUM_CHK: begin
                if (i_stat.value_zero) begin
                    o_cmd.load_byte = 1'b1;
                    o_cmd.byte_sel  = BSEL_ZERO_CHAR;
                    n_rs_byte       = 1'b1;
                    n_state         = S_BYTE;
                end else begin
                    n_state = S_MUL;
                end
            end

            // Digit extraction: multiply by the reciprocal, then store the remainder.
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUB;
            end

            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = (i_stat.quot_zero || i_stat.ndig_last) ? S_POP : S_MUL;
            end

            S_POP: begin
                o_cmd.load_byte = 1'b1;
                o_cmd.byte_sel  = BSEL_DIGIT;
                o_cmd.pop       = 1'b1;
                n_rs_byte       = 1'b1;
                n_mode          = MODE_DIGITS;
                n_phase         = 2'd0;
                n_state         = S_BYTE;
            end

            // One byte as four segments: high nibble E high, E low, low nibble E high, E low.
            S_BYTE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_phase    = r_phase + 2'd1;
                    unique case (r_phase)
                        2'd0: begin
                            o_cmd.rs_we    = 1'b1;
                            o_cmd.rs_val   = r_rs_byte;
                            o_cmd.en       = 1'b1;
                            o_cmd.nib_sel  = NSEL_HIGH;
                            o_cmd.hold_sel = HSEL_PULSE;
                        end
                        2'd2: begin
                            o_cmd.en       = 1'b1;
                            o_cmd.nib_sel  = NSEL_LOW;
                            o_cmd.hold_sel = HSEL_PULSE;
                        end
                        2'd3: begin
                            unique case (r_mode)
                                MODE_SINGLE, MODE_INIT_CLR: begin
                                    o_cmd.last = 1'b1;
                                    n_state    = S_IDLE;
                                end
                                MODE_INIT_ON: begin
                                    o_cmd.load_byte = 1'b1;
                                    o_cmd.byte_sel  = BSEL_CLEAR;
                                    n_mode          = MODE_INIT_CLR;
                                end
                                MODE_DIGITS: begin
                                    if (i_stat.ndig_zero) begin
                                        o_cmd.last = 1'b1;
                                        n_state    = S_IDLE;
                                    end else begin
                                        n_state = S_POP;
                                    end
                                end
                                default: n_state = S_IDLE;
                            endcase
                        end
                        default: begin
                            // Enable-low segment after the high nibble.
                            o_cmd.en = 1'b0;
                        end
                    endcase
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_SINGLE;
            r_phase   <= 2'd0;
            r_idx     <= 2'd0;
            r_rs_byte <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_rs_byte <= n_rs_byte;
        end
    end

endmodule

`default_nettype wire

### sim/char_lcd_nibble_write_sequencer_tb.sv
// Self-checking testbench for the character LCD 4-bit write sequencer.
// It predicts every pin-segment word from the request words and configuration writes.
// Depends on lcd4_pkg, lcd4_cmd_if, lcd4_seg_if and the sequencer top level.
module char_lcd_nibble_write_sequencer_tb;
    import lcd4_pkg::*;

    localparam int          CLK_HALF         = 5;
    localparam int          RESET_CYCLES     = 12;
    localparam int          IDLE_PAD         = 20;
    localparam int          END_PAD          = 100;
    localparam int          MAX_REPORTS      = 40;
    localparam int          HOLD_OFF_CYCLES  = 300;
    localparam int          RANDOM_PHASES    = 6;
    localparam int          ITEMS_PER_PHASE  = 14;
    localparam int          DECIMAL_BASE     = 10;
    localparam longint      TIMEOUT          = 64'd10_000_000;

    // Kinds that the sequencer takes and drops.
    localparam logic [2:0]  KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  KIND_SPARE_LAST  = 3'd7;

    // Pin levels and cursor command bits.
    localparam logic        RS_COMMAND       = 1'b0;
    localparam logic        RS_DATA          = 1'b1;
    localparam logic        EN_HIGH          = 1'b1;
    localparam logic        EN_LOW           = 1'b0;
    localparam logic [7:0]  CURSOR_CMD       = 8'h80;
    localparam logic [7:0]  ROW_OFFSET       = 8'h40;

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nib;
        logic [7:0] hold;
        logic       last;
    } t_seg_word;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [7:0]           cfg_data;

    lcd4_cmd_if cmd_bus ();
    lcd4_seg_if seg_bus ();

    char_lcd_nibble_write_sequencer uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd      (cmd_bus),
        .o_seg      (seg_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Pin state and registers as the sequencer should hold them.
    logic       lcd_rs;
    logic [3:0] lcd_lines;
    logic [7:0] lcd_pulse_ms;
    logic [7:0] lcd_power_ms;

    t_seg_word  segs_pending[$];
    int         error_count   = 0;
    int         segs_checked  = 0;
    int         requests_sent = 0;
    int         spare_sent    = 0;
    int         hold_off_len  = 0;
    bit         seg_idle_en   = 1'b1;
    bit         cmd_gap_en    = 1'b1;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Idle length shared by both sides: mostly none, some short, a few long.
    function automatic int random_idle_len();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll < 9) return 0;
        if (roll < 15) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_segment(input logic en, input logic [7:0] hold);
        t_seg_word w;
        w.rs   = lcd_rs;
        w.en   = en;
        w.nib  = lcd_lines;
        w.hold = hold;
        w.last = 1'b0;
        segs_pending.push_back(w);
    endfunction

    // A nibble is an enable pulse followed by enable low with no hold.
    function automatic void push_nibble(input logic [3:0] nib);
        lcd_lines = nib;
        push_segment(EN_HIGH, lcd_pulse_ms);
        push_segment(EN_LOW, 8'd0);
    endfunction

    function automatic void push_byte(input logic rs, input logic [7:0] byte_val);
        lcd_rs = rs;
        push_nibble(byte_val[7:4]);
        push_nibble(byte_val[3:0]);
    endfunction

    // Work out the segment words that one accepted request causes.
    function automatic void predict_segments(input logic [2:0] kind, input logic [31:0] value,
                                             input logic [5:0] column, input logic row);
        logic [3:0]  digits [MAX_DIGITS_DFLT];
        logic [31:0] rest;
        int          n;
        t_seg_word   w;
        case (kind)
            KIND_INIT: begin
                lcd_rs = RS_COMMAND;
                push_segment(EN_LOW, lcd_power_ms);
                push_nibble(NIB_INIT_A);
                push_nibble(NIB_INIT_A);
                push_nibble(NIB_INIT_B);
                push_byte(RS_COMMAND, BYTE_DISPLAY_ON);
                push_byte(RS_COMMAND, BYTE_CLEAR);
            end
            KIND_CMD: push_byte(RS_COMMAND, value[7:0]);
            KIND_DATA: push_byte(RS_DATA, value[7:0]);
            KIND_CURSOR: push_byte(RS_COMMAND,
                                   CURSOR_CMD | (8'(column) + (row ? ROW_OFFSET : 8'd0)));
            KIND_NUMBER: begin
                if (value == 32'd0) begin
                    push_byte(RS_DATA, ASCII_ZERO);
                end else begin
                    rest = value;
                    n = 0;
                    while (rest != 32'd0 && n < MAX_DIGITS_DFLT) begin
                        digits[n] = 4'(rest % DECIMAL_BASE);
                        rest = rest / DECIMAL_BASE;
                        n++;
                    end
                    // Most significant digit goes out first.
                    while (n > 0) begin
                        n--;
                        push_byte(RS_DATA, ASCII_ZERO + 8'(digits[n]));
                    end
                end
            end
            default: return;
        endcase
        w = segs_pending.pop_back();
        w.last = 1'b1;
        segs_pending.push_back(w);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t: segment %0d %s mismatch, expected %0h, actual %0h",
                     $time, segs_checked, field, want, got);
        end
    endtask

    // Compare one accepted segment word with the oldest prediction.
    task automatic check_segment();
        t_seg_word want;
        if (segs_pending.size() == 0) begin
            error_count++;
            $display("%0t: unexpected segment word, expected none, actual rs %0h e %0h d %0h",
                     $time, seg_bus.register_select, seg_bus.enable, seg_bus.nibble);
        end else begin
            want = segs_pending.pop_front();
            if (seg_bus.register_select !== want.rs)
                report_mismatch("register_select", want.rs, seg_bus.register_select);
            if (seg_bus.enable !== want.en)
                report_mismatch("enable", want.en, seg_bus.enable);
            if (seg_bus.nibble !== want.nib)
                report_mismatch("nibble", want.nib, seg_bus.nibble);
            if (seg_bus.hold_ms !== want.hold)
                report_mismatch("hold_ms", want.hold, seg_bus.hold_ms);
            if (seg_bus.last !== want.last)
                report_mismatch("last", want.last, seg_bus.last);
        end
        segs_checked++;
    endtask

    // Segment receiver: checks every accepted word and stalls at random or on request.
    initial begin : seg_receiver
        int stall_left;
        stall_left = 0;
        seg_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && seg_bus.valid && seg_bus.ready) check_segment();
            if (hold_off_len > 0) begin
                stall_left = hold_off_len;
                hold_off_len = 0;
            end else if (stall_left == 0 && seg_idle_en) begin
                stall_left = random_idle_len();
            end
            if (stall_left > 0) begin
                seg_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                seg_bus.ready <= 1'b1;
            end
        end
    end

    // Offer one request word and wait for it to be taken. Valid stays high
    // afterwards so that a following request can go out back to back.
    task automatic send_request(input logic [2:0] kind, input logic [31:0] value,
                                input logic [5:0] column, input logic row);
        int gap;
        gap = cmd_gap_en ? random_idle_len() : 0;
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.kind   <= kind;
        cmd_bus.value  <= value;
        cmd_bus.column <= column;
        cmd_bus.row    <= row;
        do @(posedge clk); while (!cmd_bus.ready);
        predict_segments(kind, value, column, row);
        if (kind > KIND_NUMBER) spare_sent++;
        else requests_sent++;
    endtask

    // Drop valid, let every predicted word arrive, then let the block settle.
    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        while (segs_pending.size() != 0) @(posedge clk);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PULSE) lcd_pulse_ms = data;
        else lcd_power_ms = data;
    endtask

    // One random request; counted is low for a kind the block drops.
    task automatic random_request(output bit counted);
        logic [2:0]  kind;
        logic [31:0] value;
        int          roll;
        roll  = $urandom_range(0, 15);
        value = $urandom();
        if (roll == 0) kind = KIND_INIT;
        else if (roll < 4) kind = KIND_CMD;
        else if (roll < 8) kind = KIND_DATA;
        else if (roll < 11) kind = KIND_CURSOR;
        else if (roll < 15) kind = KIND_NUMBER;
        else kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        // Spread numbers over all digit counts, zero included now and then.
        if (kind == KIND_NUMBER) begin
            if ($urandom_range(0, 15) == 0) value = 32'd0;
            else value = value >> $urandom_range(0, 31);
        end
        send_request(kind, value, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        counted = (kind <= KIND_NUMBER);
    endtask

    // Reset values of both registers: init, then a command and a data byte.
    task automatic test_reset_defaults();
        send_request(KIND_INIT, $urandom(), 6'($urandom()), 1'($urandom()));
        send_request(KIND_CMD, 32'h0000_0028, 6'd0, 1'b0);
        send_request(KIND_DATA, 32'h0000_0041, 6'd0, 1'b0);
    endtask

    // Field extremes for every kind, the dropped kinds and the zero number.
    task automatic test_directed_kinds();
        send_request(KIND_CMD, 32'h0000_0000, 6'd0, 1'b0);
        send_request(KIND_CMD, 32'hFFFF_FFFF, 6'd63, 1'b1);
        send_request(KIND_DATA, 32'h0000_0000, 6'd63, 1'b1);
        send_request(KIND_DATA, 32'hABCD_12FF, 6'd0, 1'b0);
        send_request(KIND_CURSOR, 32'hFFFF_FFFF, 6'd0, 1'b0);
        send_request(KIND_CURSOR, 32'h0000_0000, 6'd63, 1'b1);
        send_request(KIND_NUMBER, 32'd0, 6'd0, 1'b0);
        send_request(KIND_NUMBER, 32'd9, 6'd0, 1'b0);
        send_request(KIND_NUMBER, 32'd10, 6'd0, 1'b0);
        send_request(KIND_NUMBER, 32'hFFFF_FFFF, 6'd0, 1'b0);
        // Dropped kinds keep RS and the data lines; the init after them shows the data lines kept.
        send_request(KIND_SPARE_FIRST, 32'hFFFF_FFFF, 6'd63, 1'b1);
        send_request(3'd6, $urandom(), 6'($urandom()), 1'($urandom()));
        send_request(KIND_SPARE_LAST, 32'h0000_0000, 6'd0, 1'b0);
        send_request(KIND_INIT, 32'd0, 6'd0, 1'b0);
    endtask

    // Zero and full-scale register values.
    task automatic test_config_extremes();
        write_register(CFG_PULSE, 8'd0);
        write_register(CFG_POWER, 8'd0);
        send_request(KIND_INIT, 32'd0, 6'd0, 1'b0);
        send_request(KIND_CMD, 32'h0000_00A5, 6'd0, 1'b0);
        write_register(CFG_PULSE, 8'd255);
        write_register(CFG_POWER, 8'd255);
        send_request(KIND_INIT, 32'd0, 6'd0, 1'b0);
        send_request(KIND_NUMBER, 32'd1_000_000_000, 6'd0, 1'b0);
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // then the sender waits for every word before going on.
    task automatic test_backpressure();
        bit counted;
        int sent;
        cmd_gap_en = 1'b0;
        hold_off_len = HOLD_OFF_CYCLES;
        sent = 0;
        while (sent < 5) begin
            random_request(counted);
            if (counted) sent++;
        end
        wait_idle();
        cmd_gap_en = 1'b1;
    endtask

    // Random traffic in phases, each with its own register settings.
    task automatic test_random_traffic();
        bit         counted;
        int         used;
        logic [7:0] pulse;
        logic [7:0] power;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pulse = (phase == 1) ? 8'd0 : (phase == 2) ? 8'd255 : 8'($urandom_range(0, 255));
            power = (phase == 1) ? 8'd255 : (phase == 2) ? 8'd0 : 8'($urandom_range(0, 255));
            write_register(CFG_PULSE, pulse);
            write_register(CFG_POWER, power);
            // One phase runs with no idling on either side.
            seg_idle_en = (phase != 3);
            cmd_gap_en  = (phase != 3);
            used = 0;
            while (used < ITEMS_PER_PHASE) begin
                random_request(counted);
                if (counted) used++;
            end
        end
        seg_idle_en = 1'b1;
        cmd_gap_en  = 1'b1;
    endtask

    initial begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_PULSE;
        cfg_data       <= 8'd0;
        cmd_bus.valid  <= 1'b0;
        cmd_bus.kind   <= KIND_INIT;
        cmd_bus.value  <= 32'd0;
        cmd_bus.column <= 6'd0;
        cmd_bus.row    <= 1'b0;
        lcd_rs       = RS_COMMAND;
        lcd_lines    = 4'd0;
        lcd_pulse_ms = PULSE_MS_RST;
        lcd_power_ms = POWER_MS_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_kinds();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (END_PAD) @(posedge clk);
        if (segs_pending.size() != 0) begin
            error_count++;
            $display("%0t: %0d segment words predicted but never seen", $time,
                     segs_pending.size());
        end
        $display("Run covered %0d requests of kinds 0 to 4 and %0d dropped requests,",
                 requests_sent, spare_sent);
        $display("with %0d segment words checked and %0d mismatches.", segs_checked,
                 error_count);
        if (error_count == 0) begin
            $display("char_lcd_nibble_write_sequencer regression: pass");
        end else begin
            $display("char_lcd_nibble_write_sequencer regression: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #TIMEOUT;
        $display("%0t: run did not finish in time", $time);
        $display("char_lcd_nibble_write_sequencer regression: fail");
        $finish;
    end

endmodule
